### rtl/rc4fb_pkg.sv
// ============================================================================
// RC4 feedback cipher package
// Shared types and constants for the RC4-style cipher with plaintext feedback.
// ============================================================================
package rc4fb_pkg;

    // Table and byte geometry.
    localparam int unsigned TABLE_DEPTH = 256;
    localparam logic [7:0]  BYTE_MAX    = 8'hFF;

    // Input item modes.
    typedef enum logic [1:0] {
        MODE_KEY  = 2'd0,
        MODE_DEC  = 2'd1,
        MODE_ENC  = 2'd2,
        MODE_RSVD = 2'd3
    } t_mode;

    // Controller states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FILL,
        S_KS_RD,
        S_KS_ACC,
        S_KS_W1,
        S_KS_W2,
        S_KS_END,
        S_D_RDJ,
        S_D_SWI,
        S_D_SWJ,
        S_D_OUT
    } t_state;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_FILL,
        DP_KS_RD,
        DP_KS_ACC,
        DP_KS_W1,
        DP_KS_W2,
        DP_KS_END,
        DP_D_RDJ,
        DP_D_SWI,
        DP_D_SWJ,
        DP_D_OUT
    } t_dp_op;

    // Controller to datapath command.
    typedef struct packed {
        t_dp_op op;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic sweep_last;
    } t_stat;

endpackage

### rtl/rc4fb_if.sv
// ============================================================================
// RC4 feedback cipher channel interfaces
// Valid/ready channels for input items and result bytes.
// ============================================================================

// Input item channel: one transfer carries mode, data byte and key flag.
interface rc4fb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       last_key;

    modport source (output valid, output mode, output data_byte, output last_key,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input last_key,
                    output ready);
endinterface

// Result channel: one transfer carries one output byte.
interface rc4fb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

### rtl/rc4fb_ctrl.sv
// ============================================================================
// RC4 feedback cipher controller
// Sequences the reset clear, key schedule and data byte steps, and owns the
// input ready and output valid handshake signals.
// ============================================================================
module rc4fb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_in_mode,
    input  logic              i_in_last_key,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rc4fb_pkg::t_cmd   o_cmd,
    input  rc4fb_pkg::t_stat  i_stat
);
    import rc4fb_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_load;

    // The result register can take a new byte when empty or being drained.
    assign out_load = (r_state == S_D_OUT) && (!r_out_valid || i_out_ready);

    // State register and output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Output valid: set on load, cleared when the waiting byte is transferred.
    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_in_mode == MODE_KEY && i_in_last_key) begin
                        n_state = S_FILL;
                    end else if (i_in_mode == MODE_DEC || i_in_mode == MODE_ENC) begin
                        n_state = S_D_RDJ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FILL: begin
                if (i_stat.sweep_last) n_state = S_KS_RD;
            end
            S_KS_RD:  n_state = S_KS_ACC;
            S_KS_ACC: n_state = S_KS_W1;
            S_KS_W1:  n_state = S_KS_W2;
            S_KS_W2: begin
                n_state = i_stat.sweep_last ? S_KS_END : S_KS_RD;
            end
            S_KS_END: n_state = S_IDLE;
            S_D_RDJ:  n_state = S_D_SWI;
            S_D_SWI:  n_state = S_D_SWJ;
            S_D_SWJ:  n_state = S_D_OUT;
            S_D_OUT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Outputs: handshake and datapath command.
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.op   = DP_NOP;
        unique case (r_state)
            S_CLEAR:  o_cmd.op = DP_FILL;
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = DP_ACCEPT;
            end
            S_FILL:   o_cmd.op = DP_FILL;
            S_KS_RD:  o_cmd.op = DP_KS_RD;
            S_KS_ACC: o_cmd.op = DP_KS_ACC;
            S_KS_W1:  o_cmd.op = DP_KS_W1;
            S_KS_W2:  o_cmd.op = DP_KS_W2;
            S_KS_END: o_cmd.op = DP_KS_END;
            S_D_RDJ:  o_cmd.op = DP_D_RDJ;
            S_D_SWI:  o_cmd.op = DP_D_SWI;
            S_D_SWJ:  o_cmd.op = DP_D_SWJ;
            S_D_OUT: begin
                if (out_load) o_cmd.op = DP_D_OUT;
            end
            default:  o_cmd.op = DP_NOP;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/rc4fb_dpath.sv
// ============================================================================
// RC4 feedback cipher datapath
// Holds the permutation table, key store, indices, feedback and the result
// register, and carries out one operation per cycle as commanded.
// ============================================================================
module rc4fb_dpath #(
    parameter int unsigned KEY_MAX = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rc4fb_pkg::t_cmd   i_cmd,
    output rc4fb_pkg::t_stat  o_stat,
    input  logic [1:0]        i_mode,
    input  logic [7:0]        i_data_byte,
    output logic [7:0]        o_out_byte
);
    import rc4fb_pkg::*;

    localparam int unsigned CW = $clog2(KEY_MAX + 1);
    localparam int unsigned KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    // Memories.
    logic [7:0] perm_mem [0:TABLE_DEPTH-1];
    logic [7:0] key_mem  [0:KEY_MAX-1];

    // Control registers.
    logic [7:0]    r_n;
    logic [KW-1:0] r_k;
    logic [CW-1:0] r_count;
    logic [7:0]    r_acc;
    logic [7:0]    r_i;
    logic [7:0]    r_j;
    logic [7:0]    r_fb;

    // Payload registers.
    logic [7:0] r_s_rd;
    logic [7:0] r_key_rd;
    logic [7:0] r_sn;
    logic [7:0] r_si;
    logic [7:0] r_t;
    logic [7:0] r_data;
    logic       r_dec;
    logic [7:0] r_out;

    // Memory port controls.
    logic          s_we;
    logic [7:0]    s_waddr;
    logic [7:0]    s_wdata;
    logic          s_re;
    logic [7:0]    s_raddr;
    logic          k_we;
    logic [KW-1:0] k_raddr;

    // Arithmetic.
    logic [7:0]    acc_n;
    logic [7:0]    i_inc;
    logic [7:0]    j_n;
    logic [CW-1:0] k_inc;
    logic [KW-1:0] k_n;
    logic [7:0]    ks_byte;
    logic [7:0]    res_byte;
    logic          is_data;
    logic          key_room;

    assign acc_n    = r_acc + r_key_rd + r_s_rd;
    assign i_inc    = r_i + 8'd1;
    assign j_n      = r_j + r_s_rd;
    assign k_inc    = CW'(r_k) + CW'(1);
    assign k_n      = (k_inc == r_count) ? '0 : k_inc[KW-1:0];
    assign is_data  = (i_mode == MODE_DEC) || (i_mode == MODE_ENC);
    assign key_room = (r_count < CW'(KEY_MAX));

    // Keystream byte; the swapped entry at j is forwarded when read in the
    // same cycle it was written.
    assign ks_byte  = (r_t == r_j) ? r_si : r_s_rd;
    assign res_byte = r_data ^ ks_byte ^ r_fb;

    assign o_stat.sweep_last = (r_n == BYTE_MAX);

    // Memory port selection per operation.
    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_n;
        s_wdata = r_n;
        s_re    = 1'b0;
        s_raddr = r_n;
        k_we    = 1'b0;
        k_raddr = '0;
        unique case (i_cmd.op)
            DP_ACCEPT: begin
                k_we    = (i_mode == MODE_KEY) && key_room;
                s_re    = is_data;
                s_raddr = i_inc;
            end
            DP_FILL: begin
                s_we = 1'b1;
            end
            DP_KS_RD: begin
                s_re    = 1'b1;
                k_raddr = r_k;
            end
            DP_KS_ACC: begin
                s_re    = 1'b1;
                s_raddr = acc_n;
            end
            DP_KS_W1: begin
                s_we    = 1'b1;
                s_wdata = r_s_rd;
            end
            DP_KS_W2: begin
                s_we    = 1'b1;
                s_waddr = r_acc;
                s_wdata = r_sn;
            end
            DP_D_RDJ: begin
                s_re    = 1'b1;
                s_raddr = j_n;
            end
            DP_D_SWI: begin
                s_we    = 1'b1;
                s_waddr = r_i;
                s_wdata = r_s_rd;
            end
            DP_D_SWJ: begin
                s_we    = 1'b1;
                s_waddr = r_j;
                s_wdata = r_si;
                s_re    = 1'b1;
                s_raddr = r_t;
            end
            DP_NOP, DP_KS_END, DP_D_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // Permutation table memory with registered, read-first data.
    always_ff @(posedge i_clk) begin
        if (s_we) perm_mem[s_waddr] <= s_wdata;
        if (s_re) r_s_rd <= perm_mem[s_raddr];
    end

    // Key store memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (k_we) key_mem[r_count[KW-1:0]] <= i_data_byte;
        r_key_rd <= key_mem[k_raddr];
    end

    // Sweep counter, key index, accumulator, indices, feedback and key count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n     <= '0;
            r_k     <= '0;
            r_count <= '0;
            r_acc   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_fb    <= '0;
        end else begin
            unique case (i_cmd.op)
                DP_ACCEPT: begin
                    if (k_we) r_count <= r_count + CW'(1);
                    if (is_data) r_i <= i_inc;
                end
                DP_FILL: begin
                    r_n <= r_n + 8'd1;
                end
                DP_KS_ACC: begin
                    r_acc <= acc_n;
                end
                DP_KS_W2: begin
                    r_n <= r_n + 8'd1;
                    r_k <= k_n;
                end
                DP_KS_END: begin
                    r_fb    <= r_key_rd;
                    r_i     <= '0;
                    r_j     <= '0;
                    r_count <= '0;
                    r_k     <= '0;
                    r_acc   <= '0;
                end
                DP_D_RDJ: begin
                    r_j <= j_n;
                end
                DP_D_OUT: begin
                    r_fb <= r_fb ^ (r_dec ? res_byte : r_data);
                end
                DP_NOP, DP_KS_RD, DP_KS_W1, DP_D_SWI, DP_D_SWJ: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Payload captures.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_ACCEPT) begin
            r_data <= i_data_byte;
            r_dec  <= (i_mode == MODE_DEC);
        end
        if (i_cmd.op == DP_KS_ACC) r_sn <= r_s_rd;
        if (i_cmd.op == DP_D_RDJ)  r_si <= r_s_rd;
        if (i_cmd.op == DP_D_SWI)  r_t  <= r_si + r_s_rd;
        if (i_cmd.op == DP_D_OUT)  r_out <= res_byte;
    end

    assign o_out_byte = r_out;

endmodule

### rtl/rc4_feedback_stream_cipher.sv
// ============================================================================
// RC4 feedback stream cipher
// Byte-wide RC4-style cipher with a plaintext feedback register, built as a
// controller and a datapath around one permutation table memory.
// ============================================================================
//
//  Channel   Direction  Payload                         Transfer
//  i_in      in         mode, data_byte, last_key       valid & ready
//  o_out     out        out_byte (data modes only)      valid & ready
//
//  A key byte without the last flag, or a reserved mode, is accepted and the block stays idle.
//  A data byte runs through these steps: accept with the read at i, the read at j, two swap
//  writes with the keystream read in the second, and the result load.
//  The last key byte runs: accept, an identity fill of all 256 table entries, 256 schedule
//  steps (read, accumulate, two writes) and a closing step. Reset starts the same fill, input closed.
//  A full, stalled result register holds the next data byte in its last step.
//
module rc4_feedback_stream_cipher #(
    parameter int unsigned KEY_MAX = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rc4fb_in_if.sink    i_in,
    rc4fb_out_if.source o_out
);
    import rc4fb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencing and handshake control.
    rc4fb_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_in_mode     (i_in.mode),
        .i_in_last_key (i_in.last_key),
        .o_in_ready    (i_in.ready),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_cmd         (cmd),
        .i_stat        (stat)
    );

    // Table, key store and cipher arithmetic.
    rc4fb_dpath #(
        .KEY_MAX (KEY_MAX)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_mode      (i_in.mode),
        .i_data_byte (i_in.data_byte),
        .o_out_byte  (o_out.out_byte)
    );

endmodule

### rtl/rc4fb_checker.sv
// ============================================================================
// RC4 feedback cipher port checker
// Concurrent checks on the top-level ports, attached by a bind statement.
// ============================================================================
module rc4fb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_mode,
    input logic       i_in_last_key,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte
);
    import rc4fb_pkg::*;

    // A waiting result stays offered until it is transferred.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    // A waiting result keeps its byte.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte))
        else $error("result byte changed while stalled");

    // The table clearing pass keeps the input closed right after reset.
    a_clear_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input open during clearing pass");

    // A data byte or a final key byte occupies the block in the next cycle.
    a_work_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready &&
        (i_in_mode == MODE_DEC || i_in_mode == MODE_ENC ||
         (i_in_mode == MODE_KEY && i_in_last_key)) |=> !i_in_ready)
        else $error("input open while an item is in progress");

    // A new result appears only out of a busy step.
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without work in progress");

endmodule

bind rc4_feedback_stream_cipher rc4fb_checker u_rc4fb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_mode     (i_in.mode),
    .i_in_last_key (i_in.last_key),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_byte    (o_out.out_byte)
);
